[rtl/i2cbm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and timing constants of the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   // Command codes carried on the request channel
   localparam logic [2:0] OPC_TICK  = 3'd0;
   localparam logic [2:0] OPC_START = 3'd1;
   localparam logic [2:0] OPC_STOP  = 3'd2;
   localparam logic [2:0] OPC_SEND  = 3'd3;
   localparam logic [2:0] OPC_READ  = 3'd4;

   localparam logic [7:0] MSB_MASK = 8'h80;

   // Phase marks within each command
   localparam logic [5:0] START_SDA_LOW  = 6'd2;
   localparam logic [5:0] START_LAST     = 6'd2;
   localparam logic [5:0] STOP_SDA_LOW   = 6'd2;
   localparam logic [5:0] STOP_SCL_HIGH  = 6'd4;
   localparam logic [5:0] STOP_LAST      = 6'd5;
   localparam logic [5:0] SEND_ACK_FIRST = 6'd32;
   localparam logic [5:0] READ_ACK_FIRST = 6'd24;
   localparam logic [5:0] READ_ACK_SCL   = 6'd26;
   localparam logic [5:0] READ_LAST      = 6'd27;
   localparam logic [1:0] READ_SUB_LAST  = 2'd2;

   // Running command, one-hot
   typedef enum logic [4:0] {
      OP_IDLE  = 5'b00001,
      OP_START = 5'b00010,
      OP_STOP  = 5'b00100,
      OP_SEND  = 5'b01000,
      OP_READ  = 5'b10000
   } op_state_type;

   typedef struct packed {
      op_state_type op;
      logic [5:0]   phase;
      logic [1:0]   sub;        // bit slot within a read bit (0..2)
      logic [7:0]   tx_shift;
      logic [7:0]   rx_shift;
      logic         ack_choice;
      logic         scl;
      logic         sda;
      logic         sda_in_mode;
      logic         ack_seen;
   } bm_state_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_sampled;
   } bm_cmd_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_released;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
      logic       refused;
   } bm_result_type;

endpackage

[rtl/i2c_bit_level_master.sv]
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// The response to a request is registered at the edge that accepts it.
// Throughput: one request per cycle unless the response stalls; each request is one
//   delay unit; the sequencer step is one combinational pass into the state register.
// Reset (synchronous, active high): sequencer idle, SCL and SDA held high,
//   SDA driven, response register empty.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tx_byte, [8] ack_to_send, [9] sda_sampled
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] scl_level, [1] sda_level, [2] sda_released,
                                    // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                    // [13] ack_error, [14] refused
);
   import i2cbm_pkg::*;

   localparam bm_state_type STATE_RESET = '{
      op:          OP_IDLE,
      phase:       6'd0,
      sub:         2'd0,
      tx_shift:    8'd0,
      rx_shift:    8'd0,
      ack_choice:  1'b0,
      scl:         1'b1,
      sda:         1'b1,
      sda_in_mode: 1'b0,
      ack_seen:    1'b0
   };

   bm_state_type  state_ff, state_in;
   bm_cmd_type    cmd;
   bm_result_type res;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          req_accept;

   // The response register frees up whenever its content leaves this cycle,
   // so a steady stream moves one request per clock while rsp_tready stays high.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   // opcode, tx_byte, ack_to_send, sda_sampled from the top bit down
   assign cmd = {req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9]};

   // One delay unit of the command sequencer
   i2cbm_step u_step (
      .cur (state_ff),
      .cmd (cmd),
      .nxt (state_in),
      .res (res)
   );

   assign rsp_data_in = {1'b0, res.refused, res.ack_error, res.rx_byte, res.done_res,
                         res.busy_res, res.sda_released, res.sda_level, res.scl_level};
   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // a refused command never stops the command that is running
   a_refuse_while_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[14]) |-> (rsp_tdata[3] || rsp_tdata[4]))
      else $error("refused response without a running command");

   // busy and done are exclusive
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[4]))
      else $error("busy and done on the same unit");

   // an idle sequencer sits at phase zero
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff.op == OP_IDLE) |-> (state_ff.phase == 6'd0))
      else $error("idle sequencer with nonzero phase");

   // state only advances on an accepted request
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!req_accept) |=> $stable(state_ff))
      else $error("sequencer state moved without a request");

endmodule

[rtl/i2cbm_step.sv]
// ----------------------------------------------------------------------------
// i2cbm_step
// Next-state and result logic for one delay unit of the bit-level master.
// ----------------------------------------------------------------------------
module i2cbm_step (
   input  i2cbm_pkg::bm_state_type  cur,
   input  i2cbm_pkg::bm_cmd_type    cmd,
   output i2cbm_pkg::bm_state_type  nxt,
   output i2cbm_pkg::bm_result_type res
);
   import i2cbm_pkg::*;

   bm_state_type st;
   logic         is_cmd;
   logic         run;
   logic         last;
   logic [1:0]   q;

   always_comb begin
      st     = cur;
      last   = 1'b0;
      q      = 2'b00;
      res    = '0;
      is_cmd = (cmd.opcode >= OPC_START) && (cmd.opcode <= OPC_READ);

      // command launch or refusal
      if (is_cmd) begin
         if (cur.op != OP_IDLE) begin
            res.refused = 1'b1;
         end else begin
            st.phase = '0;
            st.sub   = '0;
            case (cmd.opcode)
               OPC_START: st.op = OP_START;
               OPC_STOP:  st.op = OP_STOP;
               OPC_SEND: begin
                  st.op       = OP_SEND;
                  st.tx_shift = cmd.tx_byte;
                  st.ack_seen = 1'b0;
               end
               OPC_READ: begin
                  st.op         = OP_READ;
                  st.rx_shift   = '0;
                  st.ack_choice = cmd.ack_to_send;
               end
               default: ;
            endcase
         end
      end

      run = (st.op != OP_IDLE);

      // line levels for this phase
      unique case (st.op)
         OP_IDLE: ;
         OP_START: begin
            st.scl = 1'b1;
            st.sda = (st.phase < START_SDA_LOW);
            last   = (st.phase >= START_LAST);
         end
         OP_STOP: begin
            st.scl = (st.phase >= STOP_SCL_HIGH);
            if (st.phase >= STOP_SDA_LOW) begin
               st.sda = 1'b0;
            end
            last = (st.phase >= STOP_LAST);
         end
         OP_SEND: begin
            q = st.phase[1:0];
            if (st.phase < SEND_ACK_FIRST) begin
               st.sda_in_mode = 1'b0;
               if (q == 2'd0) begin
                  st.sda      = |(st.tx_shift & MSB_MASK);
                  st.tx_shift = {st.tx_shift[6:0], 1'b0};
                  st.scl      = 1'b0;
               end else if (q == 2'd3) begin
                  st.scl = 1'b0;
               end else begin
                  st.scl = 1'b1;
               end
            end else begin
               st.sda_in_mode = 1'b1;
               st.scl         = q[1];
               if (q == 2'd2) begin
                  st.ack_seen = cmd.sda_sampled;
               end
               last = (q == 2'd3);
            end
         end
         OP_READ: begin
            if (st.phase < READ_ACK_FIRST) begin
               st.sda_in_mode = 1'b1;
               if (st.sub == 2'd0) begin
                  st.scl      = 1'b1;
                  st.rx_shift = {st.rx_shift[6:0], cmd.sda_sampled};
               end else begin
                  st.scl = 1'b0;
               end
            end else begin
               st.sda_in_mode = 1'b0;
               st.sda         = ~st.ack_choice;
               st.scl         = (st.phase >= READ_ACK_SCL);
               last           = (st.phase >= READ_LAST);
            end
         end
         default: st.op = OP_IDLE;
      endcase

      res.scl_level    = st.scl;
      res.sda_level    = st.sda;
      res.sda_released = st.sda_in_mode;

      // wrap-up of the unit
      if (run) begin
         if (last) begin
            res.done_res = 1'b1;
            unique case (st.op)
               OP_START: st.scl = 1'b0;
               OP_STOP:  st.sda = 1'b1;
               OP_SEND: begin
                  st.scl         = 1'b0;
                  st.sda_in_mode = 1'b0;
                  res.ack_error  = st.ack_seen;
               end
               OP_READ: begin
                  st.scl      = 1'b0;
                  res.rx_byte = st.rx_shift;
               end
               default: ;
            endcase
            st.op    = OP_IDLE;
            st.phase = '0;
            st.sub   = '0;
         end else begin
            res.busy_res = 1'b1;
            st.phase     = st.phase + 6'd1;
            st.sub       = (st.sub == READ_SUB_LAST) ? 2'd0 : st.sub + 2'd1;
         end
      end

      nxt = st;
   end

endmodule

[test/tb_i2c_bit_level_master.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Streams bus units into the I2C bit-level master and checks every response
// against an in-bench model of the start/stop/send/read timing. Directed
// sequences cover ack/nack, all-ones/all-zeros bytes, refusals and unused
// opcodes; a random phase mixes well-formed commands with noise and overlap.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;
   import i2cbm_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int RESET_CYC   = 8;
   localparam int RAND_UNITS  = 320;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 30;
   localparam int HOLD_CYC    = 120;   // long receiver hold-off
   localparam int HOLD_AT     = 150;   // responses seen before the hold-off
   localparam int BURST_LO    = 250;   // window with no idling on either side
   localparam int BURST_HI    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = OPC_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   i2c_bit_level_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Bus units waiting to be offered, and line states waiting to come back
   bm_cmd_type    pending_units[$];
   bm_result_type expected_line_states[$];

   bm_cmd_type    offered_unit;       // unit currently on the request bus
   bm_cmd_type    next_unit;
   bm_result_type seen_state;
   logic          req_taken = 1'b0;   // request handshake at the last rising edge

   int units_sent    = 0;
   int results_seen  = 0;
   int fail_count    = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   logic hold_done   = 1'b0;

   // Tallies for the closing summary
   int cmds_done     = 0;
   int refusals      = 0;
   int nacks_seen    = 0;

   // ---------------------------------------------------------------------
   // Bus model: sequencer state, advanced one unit per accepted request
   // ---------------------------------------------------------------------
   op_state_type run_op;
   logic [5:0]   unit_phase;
   logic [7:0]   tx_bits;
   logic [7:0]   rx_bits;
   logic         ack_pick;
   logic         scl_line;
   logic         sda_line;
   logic         sda_floating;
   logic         ack_level;

   function automatic bm_result_type advance_bus_unit(bm_cmd_type u);
      bm_result_type r;
      logic          last;
      op_state_type  finished;
      logic [5:0]    q;
      r        = '0;
      last     = 1'b0;
      finished = OP_IDLE;

      // new command only taken while idle; otherwise dropped and flagged
      if (u.opcode >= OPC_START && u.opcode <= OPC_READ) begin
         if (run_op != OP_IDLE) begin
            r.refused = 1'b1;
         end else begin
            unit_phase = '0;
            case (u.opcode)
               OPC_START: run_op = OP_START;
               OPC_STOP:  run_op = OP_STOP;
               OPC_SEND: begin
                  run_op    = OP_SEND;
                  tx_bits   = u.tx_byte;
                  ack_level = 1'b0;
               end
               default: begin
                  run_op   = OP_READ;
                  rx_bits  = '0;
                  ack_pick = u.ack_to_send;
               end
            endcase
         end
      end

      if (run_op != OP_IDLE) begin
         finished = run_op;
         case (run_op)
            OP_START: begin
               // SDA falls while SCL high on the third unit
               scl_line = 1'b1;
               sda_line = (unit_phase < START_SDA_LOW);
               last     = (unit_phase >= START_LAST);
            end
            OP_STOP: begin
               scl_line = (unit_phase >= STOP_SCL_HIGH);
               if (unit_phase >= STOP_SDA_LOW)
                  sda_line = 1'b0;
               last = (unit_phase >= STOP_LAST);
            end
            OP_SEND: begin
               if (unit_phase < SEND_ACK_FIRST) begin
                  // 4 units per bit: SCL 0,1,1,0; data set on the first
                  sda_floating = 1'b0;
                  case (unit_phase[1:0])
                     2'd0: begin
                        sda_line = ((tx_bits & MSB_MASK) != 0);
                        tx_bits  = {tx_bits[6:0], 1'b0};
                        scl_line = 1'b0;
                     end
                     2'd3:    scl_line = 1'b0;
                     default: scl_line = 1'b1;
                  endcase
               end else begin
                  // ack slot: SDA released, SCL 0,0,1,1, sampled on first high
                  q            = unit_phase - SEND_ACK_FIRST;
                  sda_floating = 1'b1;
                  scl_line     = (q >= 2);
                  if (q == 2)
                     ack_level = u.sda_sampled;
                  last = (q >= 3);
               end
            end
            default: begin
               if (unit_phase < READ_ACK_FIRST) begin
                  // 3 units per bit: SCL 1,0,0; sample on the high unit
                  sda_floating = 1'b1;
                  if (unit_phase % 3 == 0) begin
                     scl_line = 1'b1;
                     rx_bits  = {rx_bits[6:0], u.sda_sampled};
                  end else begin
                     scl_line = 1'b0;
                  end
               end else begin
                  sda_floating = 1'b0;
                  sda_line     = ~ack_pick;
                  scl_line     = (unit_phase >= READ_ACK_SCL);
                  last         = (unit_phase >= READ_LAST);
               end
            end
         endcase
      end

      r.scl_level    = scl_line;
      r.sda_level    = sda_line;
      r.sda_released = sda_floating;

      if (finished != OP_IDLE) begin
         if (last) begin
            r.done_res = 1'b1;
            case (finished)
               OP_START: scl_line = 1'b0;
               OP_STOP:  sda_line = 1'b1;
               OP_SEND: begin
                  scl_line     = 1'b0;
                  sda_floating = 1'b0;
                  r.ack_error  = ack_level;
               end
               default: begin
                  scl_line  = 1'b0;
                  r.rx_byte = rx_bits;
               end
            endcase
            run_op     = OP_IDLE;
            unit_phase = '0;
         end else begin
            r.busy_res = 1'b1;
            unit_phase = unit_phase + 6'd1;
         end
      end
      return r;
   endfunction

   function automatic void check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
      end
   endfunction

   function automatic void push_unit(logic [2:0] op, logic [7:0] tx, logic ack, logic sda);
      bm_cmd_type u;
      u.opcode      = op;
      u.tx_byte     = tx;
      u.ack_to_send = ack;
      u.sda_sampled = sda;
      pending_units.push_back(u);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge, holds until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_units.size() != 0 &&
             ((units_sent >= BURST_LO && units_sent < BURST_HI) ||
              $urandom_range(99) >= IDLE_PCT)) begin
            next_unit = pending_units.pop_front();
            units_sent++;
            offered_unit <= next_unit;
            req_tvalid   <= 1'b1;
            req_tdata    <= {6'b0, next_unit.sda_sampled, next_unit.ack_to_send,
                             next_unit.tx_byte};
            req_tuser    <= next_unit.opcode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response ready: random stalls, one long hold-off so the block backs up
   // into its request side, then a stretch with no stalls at all
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYC;
         rsp_tready <= 1'b0;
      end else if (results_seen >= BURST_LO && results_seen < BURST_HI) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Rising edge: check responses, then predict for the accepted request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         run_op       = OP_IDLE;
         unit_phase   = '0;
         tx_bits      = '0;
         rx_bits      = '0;
         ack_pick     = 1'b0;
         scl_line     = 1'b1;
         sda_line     = 1'b1;
         sda_floating = 1'b0;
         ack_level    = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_line_states.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response 0x%04h with nothing expected", $time, rsp_tdata);
            end else begin
               seen_state = expected_line_states.pop_front();
               check_field("scl_level",    seen_state.scl_level,    rsp_tdata[0]);
               check_field("sda_level",    seen_state.sda_level,    rsp_tdata[1]);
               check_field("sda_released", seen_state.sda_released, rsp_tdata[2]);
               check_field("busy_res",     seen_state.busy_res,     rsp_tdata[3]);
               check_field("done_res",     seen_state.done_res,     rsp_tdata[4]);
               check_field("rx_byte",      seen_state.rx_byte,      rsp_tdata[12:5]);
               check_field("ack_error",    seen_state.ack_error,    rsp_tdata[13]);
               check_field("refused",      seen_state.refused,      rsp_tdata[14]);
            end
         end
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            seen_state = advance_bus_unit(offered_unit);
            expected_line_states.push_back(seen_state);
            cmds_done  += seen_state.done_res;
            refusals   += seen_state.refused;
            nacks_seen += seen_state.ack_error;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int         n;
      int         roll;
      logic [2:0] op;

      // idle ticks with extreme field values, then the unused opcodes
      push_unit(OPC_TICK, 8'h00, 1'b0, 1'b0);
      push_unit(OPC_TICK, 8'hFF, 1'b1, 1'b1);
      for (int k = OPC_READ + 1; k < 8; k++)
         push_unit(3'(k), 8'($urandom), 1'($urandom), 1'($urandom));

      // start, with a stop arriving mid-sequence (refused)
      push_unit(OPC_START, 8'h00, 1'b0, 1'b1);
      push_unit(OPC_STOP,  8'h00, 1'b0, 1'b1);
      push_unit(OPC_TICK,  8'h00, 1'b0, 1'b1);

      // send all-zeros, slave acks; a read and an unused opcode overlap it
      push_unit(OPC_SEND, 8'h00, 1'b0, 1'b0);
      push_unit(OPC_READ, 8'hFF, 1'b1, 1'b0);
      push_unit(3'(OPC_READ + 1), 8'hFF, 1'b1, 1'b0);
      repeat (33) push_unit(OPC_TICK, 8'h00, 1'b0, 1'b0);

      // send all-ones, slave nacks; a start overlaps it
      push_unit(OPC_SEND,  8'hFF, 1'b1, 1'b1);
      push_unit(OPC_START, 8'h00, 1'b0, 1'b1);
      repeat (34) push_unit(OPC_TICK, 8'hFF, 1'b1, 1'b1);

      // read all-ones sending ack, then all-zeros sending nack
      push_unit(OPC_READ, 8'h00, 1'b1, 1'b1);
      repeat (27) push_unit(OPC_TICK, 8'h00, 1'b1, 1'b1);
      push_unit(OPC_READ, 8'hFF, 1'b0, 1'b0);
      repeat (27) push_unit(OPC_TICK, 8'hFF, 1'b0, 1'b0);

      // mixed byte, then stop with a send arriving mid-sequence
      push_unit(OPC_SEND, 8'hA5, 1'b0, 1'b0);
      repeat (35) push_unit(OPC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      push_unit(OPC_STOP, 8'h00, 1'b0, 1'b0);
      push_unit(OPC_SEND, 8'h5A, 1'b0, 1'b0);
      repeat (4) push_unit(OPC_TICK, 8'h00, 1'b0, 1'b0);

      // random part: mostly whole commands with random content, some cut
      // short or overlapped, plus loose noise units
      n = pending_units.size() + RAND_UNITS;
      while (pending_units.size() < n) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            op = 3'($urandom_range(OPC_START, OPC_READ));
            push_unit(op, 8'($urandom), 1'($urandom), 1'($urandom));
            case (op)
               OPC_START: roll = int'(START_LAST);
               OPC_STOP:  roll = int'(STOP_LAST);
               OPC_SEND:  roll = int'(SEND_ACK_FIRST) + 3;
               default:   roll = int'(READ_LAST);
            endcase
            if ($urandom_range(9) == 0)
               roll = $urandom_range(roll);
            repeat (roll) begin
               if ($urandom_range(19) == 0)
                  push_unit(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                            1'($urandom));
               else
                  push_unit(OPC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            repeat ($urandom_range(2))
               push_unit(OPC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            push_unit(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 1'($urandom));
         end
      end

      repeat (RESET_CYC) @(negedge clock);
      reset <= 1'b0;

      // drain: everything offered, taken, and answered
      while (pending_units.size() != 0 || req_tvalid || expected_line_states.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Ran %0d bus units: %0d commands finished, %0d refused, %0d ack errors seen",
               units_sent, cmds_done, refusals, nacks_seen);
      $display("Response hold-off of %0d cycles applied; %0d field mismatches",
               HOLD_CYC, fail_count);
      if (fail_count == 0 && expected_line_states.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
